// File: rtl/core/txsh_pkg.sv
`default_nettype none

package txsh_pkg;

    localparam int unsigned TABLE_ENTRIES = 110;
    localparam int unsigned SPAN_W        = 7;
    localparam int unsigned SUM_W         = 10;
    localparam int unsigned CNT_W         = 4;

    localparam logic [31:0]       HASH_SEED   = 32'hABBADEED;
    localparam logic [7:0]        PREV_SEED   = 8'hCC;
    localparam logic [SPAN_W-1:0] SPAN_FULL   = 7'd110;
    localparam logic [SPAN_W-1:0] OFFSET_LAST = 7'd109;

    function automatic logic [31:0] txsh_word(input logic [SPAN_W-1:0] sel);
        logic [31:0] w;
        case (sel)
            7'd0:   w = 32'h85465933;
            7'd1:   w = 32'h74183274;
            7'd2:   w = 32'h19374935;
            7'd3:   w = 32'h75639274;
            7'd4:   w = 32'h82471783;
            7'd5:   w = 32'h78580324;
            7'd6:   w = 32'h24754925;
            7'd7:   w = 32'h75327563;
            7'd8:   w = 32'h47762487;
            7'd9:   w = 32'h65378454;
            7'd10:  w = 32'h13162964;
            7'd11:  w = 32'h98145783;
            7'd12:  w = 32'h76478235;
            7'd13:  w = 32'h78364872;
            7'd14:  w = 32'h87637562;
            7'd15:  w = 32'h47234927;
            7'd16:  w = 32'h87648723;
            7'd17:  w = 32'h57435293;
            7'd18:  w = 32'h93462398;
            7'd19:  w = 32'h43748932;
            7'd20:  w = 32'h74637424;
            7'd21:  w = 32'h87428744;
            7'd22:  w = 32'h47247826;
            7'd23:  w = 32'h27462374;
            7'd24:  w = 32'h78326428;
            7'd25:  w = 32'h37841841;
            7'd26:  w = 32'h42749237;
            7'd27:  w = 32'h23492749;
            7'd28:  w = 32'h41984414;
            7'd29:  w = 32'h62389468;
            7'd30:  w = 32'h28946144;
            7'd31:  w = 32'h46298472;
            7'd32:  w = 32'h74672364;
            7'd33:  w = 32'h27452139;
            7'd34:  w = 32'h73629793;
            7'd35:  w = 32'h23674629;
            7'd36:  w = 32'h76597823;
            7'd37:  w = 32'h61928461;
            7'd38:  w = 32'h76491624;
            7'd39:  w = 32'h76732548;
            7'd40:  w = 32'h72641649;
            7'd41:  w = 32'h85378959;
            7'd42:  w = 32'h23568234;
            7'd43:  w = 32'h15634789;
            7'd44:  w = 32'h53462592;
            7'd45:  w = 32'h78645783;
            7'd46:  w = 32'h89259684;
            7'd47:  w = 32'h35873424;
            7'd48:  w = 32'h73578653;
            7'd49:  w = 32'h64274674;
            7'd50:  w = 32'h35893275;
            7'd51:  w = 32'h37583089;
            7'd52:  w = 32'h89725398;
            7'd53:  w = 32'h98237534;
            7'd54:  w = 32'h97853298;
            7'd55:  w = 32'h84732980;
            7'd56:  w = 32'h23572843;
            7'd57:  w = 32'h98327424;
            7'd58:  w = 32'h98327424;
            7'd59:  w = 32'h55852803;
            7'd60:  w = 32'h28394752;
            7'd61:  w = 32'h56234434;
            7'd62:  w = 32'h97213948;
            7'd63:  w = 32'h91479344;
            7'd64:  w = 32'h89749198;
            7'd65:  w = 32'h12701273;
            7'd66:  w = 32'h09747124;
            7'd67:  w = 32'h74128471;
            7'd68:  w = 32'h18734879;
            7'd69:  w = 32'h80748187;
            7'd70:  w = 32'h98714944;
            7'd71:  w = 32'h89759327;
            7'd72:  w = 32'h87695487;
            7'd73:  w = 32'h76491413;
            7'd74:  w = 32'h28740917;
            7'd75:  w = 32'h80941478;
            7'd76:  w = 32'h97632947;
            7'd77:  w = 32'h98701355;
            7'd78:  w = 32'h97532944;
            7'd79:  w = 32'h97834974;
            7'd80:  w = 32'h89743918;
            7'd81:  w = 32'h45378543;
            7'd82:  w = 32'h50475345;
            7'd83:  w = 32'h74534385;
            7'd84:  w = 32'h87401247;
            7'd85:  w = 32'h87529075;
            7'd86:  w = 32'h87534794;
            7'd87:  w = 32'h79278409;
            7'd88:  w = 32'h42374084;
            7'd89:  w = 32'h09782304;
            7'd90:  w = 32'h47297402;
            7'd91:  w = 32'h98274238;
            7'd92:  w = 32'h87098704;
            7'd93:  w = 32'h43298478;
            7'd94:  w = 32'h57529434;
            7'd95:  w = 32'h32947298;
            7'd96:  w = 32'h98749344;
            7'd97:  w = 32'h76349524;
            7'd98:  w = 32'h21436149;
            7'd99:  w = 32'h43267491;
            7'd100: w = 32'h76498442;
            7'd101: w = 32'h97649144;
            7'd102: w = 32'h19284714;
            7'd103: w = 32'h97649143;
            7'd104: w = 32'h87414780;
            7'd105: w = 32'h78494720;
            7'd106: w = 32'h91649344;
            7'd107: w = 32'h76941443;
            7'd108: w = 32'h93497442;
            7'd109: w = 32'h99483223;
            default: w = 32'h00000000;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/txsh_mod.sv
`default_nettype none

// Restoring remainder: one dividend bit per cycle, one shared compare/subtract.
module txsh_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [txsh_pkg::SUM_W-1:0]  dividend,
    input  wire logic [txsh_pkg::SPAN_W-1:0] divisor,
    output logic                             done,
    output logic [txsh_pkg::SPAN_W-1:0]      remainder
);
    import txsh_pkg::*;

    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [SPAN_W-1:0] dvs_reg, dvs_next;
    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [SPAN_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[SUM_W-1]};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(SUM_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
                rem_next = SPAN_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[SPAN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/table_xor_string_hash_top.sv
// Flow per byte: accept, the remainder loop over the 10 dividend bits (one bit a step
// through a single compare/subtract unit), fold of the table word, finish (last byte).
// A new byte is accepted only after the previous one has been through finish.
// A hash still waiting at the output holds the finish of the next last byte.
// Reset (rst_n, async, active low): hash 0xABBADEED, previous byte 0xCC,
// offset 0, span 110, no result pending, ready for the first byte.
`default_nettype none

module table_xor_string_hash_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  byte_index,
    input  wire logic        first_of_string,
    input  wire logic        last_of_string,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);
    import txsh_pkg::*;

    // One-hot sequencer: wait for a byte, run the remainder, fold the word in, finish (emit on last).
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CALC   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [31:0]       hash_reg, hash_next;
    logic [7:0]        prev_reg, prev_next;
    logic [SPAN_W-1:0] offset_reg, offset_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic              last_reg, last_next;
    logic              ovalid_reg, ovalid_next;
    logic [31:0]       odata_reg, odata_next;

    logic              accept;
    logic [7:0]        eff_prev;
    logic [SPAN_W-1:0] eff_offset;
    logic [SPAN_W-1:0] eff_span;
    logic [SPAN_W-1:0] new_offset;
    logic [SPAN_W-1:0] room;
    logic [7:0]        masked;
    logic [SPAN_W-1:0] span_cut;
    logic [SUM_W-1:0]  sum;
    logic              div_done;
    logic [SPAN_W-1:0] div_rem;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // A first flag restarts from the seed values before this byte is used.
    assign eff_prev   = first_of_string ? PREV_SEED : prev_reg;
    assign eff_offset = first_of_string ? '0 : offset_reg;
    always_comb
    begin
        if (first_of_string || span_reg == '0 || span_reg > SPAN_FULL)
            eff_span = SPAN_FULL;
        else
            eff_span = span_reg;
    end

    assign sum = SUM_W'(data_byte) + SUM_W'(eff_prev) + SUM_W'(eff_offset);

    // Next offset and span depend only on the byte, index and offset.
    assign new_offset = (eff_offset == OFFSET_LAST) ? '0 : eff_offset + 1'b1;
    assign room       = OFFSET_LAST - new_offset;
    assign masked     = data_byte & ~byte_index;
    assign span_cut   = (masked < {1'b0, room}) ? masked[SPAN_W-1:0] : room;

    txsh_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (sum),
        .divisor   (eff_span),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        prev_next   = prev_reg;
        offset_next = offset_reg;
        span_next   = span_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;

        // Drop the pending result once the consumer takes it.
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hash_next   = first_of_string ? HASH_SEED : hash_reg;
                    prev_next   = data_byte;
                    offset_next = new_offset;
                    span_next   = SPAN_FULL - span_cut;
                    last_next   = last_of_string;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (div_done)
                begin
                    hash_next  = hash_reg ^ txsh_word(div_rem);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (!ovalid_reg || out_ready)
                begin
                    // Emit the hash, then restore the seed state for the next string.
                    odata_next  = hash_reg;
                    ovalid_next = 1'b1;
                    hash_next   = HASH_SEED;
                    prev_next   = PREV_SEED;
                    offset_next = '0;
                    span_next   = SPAN_FULL;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hash_reg   <= HASH_SEED;
            prev_reg   <= PREV_SEED;
            offset_reg <= '0;
            span_reg   <= SPAN_FULL;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            prev_reg   <= prev_next;
            offset_reg <= offset_next;
            span_reg   <= span_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign out_valid  = ovalid_reg;
    assign hash_value = odata_reg;

endmodule

`default_nettype wire

// File: bench/table_xor_string_hash_top_test.sv
`timescale 1ns / 100ps

module table_xor_string_hash_top_test;

    import txsh_pkg::*;

    // Hard stop for a hung design.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Wait allowance, in cycles, for a stray late output after the final drain.
    localparam int unsigned HASH_LATENCY = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic [7:0]  byte_index = 8'h00;
    logic        first_of_string = 1'b0;
    logic        last_of_string = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] hash_value;

    // Word table the hash mixes in, indexed by the reduced selector.
    logic [31:0] mix_words [0:109] = '{
        32'h85465933, 32'h74183274, 32'h19374935, 32'h75639274, 32'h82471783,
        32'h78580324, 32'h24754925, 32'h75327563, 32'h47762487, 32'h65378454,
        32'h13162964, 32'h98145783, 32'h76478235, 32'h78364872, 32'h87637562,
        32'h47234927, 32'h87648723, 32'h57435293, 32'h93462398, 32'h43748932,
        32'h74637424, 32'h87428744, 32'h47247826, 32'h27462374, 32'h78326428,
        32'h37841841, 32'h42749237, 32'h23492749, 32'h41984414, 32'h62389468,
        32'h28946144, 32'h46298472, 32'h74672364, 32'h27452139, 32'h73629793,
        32'h23674629, 32'h76597823, 32'h61928461, 32'h76491624, 32'h76732548,
        32'h72641649, 32'h85378959, 32'h23568234, 32'h15634789, 32'h53462592,
        32'h78645783, 32'h89259684, 32'h35873424, 32'h73578653, 32'h64274674,
        32'h35893275, 32'h37583089, 32'h89725398, 32'h98237534, 32'h97853298,
        32'h84732980, 32'h23572843, 32'h98327424, 32'h98327424, 32'h55852803,
        32'h28394752, 32'h56234434, 32'h97213948, 32'h91479344, 32'h89749198,
        32'h12701273, 32'h09747124, 32'h74128471, 32'h18734879, 32'h80748187,
        32'h98714944, 32'h89759327, 32'h87695487, 32'h76491413, 32'h28740917,
        32'h80941478, 32'h97632947, 32'h98701355, 32'h97532944, 32'h97834974,
        32'h89743918, 32'h45378543, 32'h50475345, 32'h74534385, 32'h87401247,
        32'h87529075, 32'h87534794, 32'h79278409, 32'h42374084, 32'h09782304,
        32'h47297402, 32'h98274238, 32'h87098704, 32'h43298478, 32'h57529434,
        32'h32947298, 32'h98749344, 32'h76349524, 32'h21436149, 32'h43267491,
        32'h76498442, 32'h97649144, 32'h19284714, 32'h97649143, 32'h87414780,
        32'h78494720, 32'h91649344, 32'h76941443, 32'h93497442, 32'h99483223
    };

    // Shadow copy of the hash state, advanced once per accepted byte.
    logic [31:0] model_hash;
    logic [7:0]  model_prev;
    logic [6:0]  model_offset;
    logic [6:0]  model_span;

    logic [31:0] pending_hashes [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;

    table_xor_string_hash_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .byte_index      (byte_index),
        .first_of_string (first_of_string),
        .last_of_string  (last_of_string),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hash_value      (hash_value)
    );

    always #10 clk = ~clk;

    // Watchdog: abort the run if the design hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stall about a quarter of the cycles unless idling is switched off.
    always @(posedge clk)
    begin
        out_ready <= !idle_on || ($urandom_range(99) >= 25);
    end

    // Compare every accepted output transaction against the oldest predicted hash.
    always @(posedge clk)
    begin : check_hash
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $error("hash_value: no hash expected, actual %08h", hash_value);
                error_count++;
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (hash_value !== want)
                begin
                    $error("hash_value: expected %08h, actual %08h", want, hash_value);
                    error_count++;
                end
            end
        end
    end

    // Return the shadow state to its power-on values.
    task automatic restart_hash();
        model_hash   = HASH_SEED;
        model_prev   = PREV_SEED;
        model_offset = '0;
        model_span   = SPAN_FULL;
    endtask

    // Advance the shadow state by one byte; queue the hash on the last byte.
    task automatic hash_step(input logic [7:0] d, input logic [7:0] idx,
                             input logic first, input logic last);
        logic [6:0]  span;
        logic [6:0]  pick;
        logic [6:0]  room;
        logic [7:0]  masked;
        int unsigned sum;
        if (first)
            restart_hash();
        span = (model_span == 0 || model_span > TABLE_ENTRIES) ? SPAN_FULL : model_span;
        sum = d + model_prev + model_offset;
        pick = 7'(sum % span);
        model_hash ^= mix_words[pick];
        // Advance the offset with wrap, then shrink the span by the masked byte,
        // clamped so the span never drops below offset + 1.
        model_offset = (model_offset == OFFSET_LAST) ? 7'd0 : model_offset + 7'd1;
        room = OFFSET_LAST - model_offset;
        masked = d & ~idx;
        model_span = SPAN_FULL - ((masked < room) ? masked[6:0] : room);
        model_prev = d;
        if (last)
        begin
            pending_hashes.push_back(model_hash);
            restart_hash();
        end
    endtask

    // Drive one byte transaction, hold it until accepted, then predict it.
    // Valid is left high so back-to-back bytes follow without a gap in valid.
    task automatic feed_byte(input logic [7:0] d, input logic [7:0] idx,
                             input logic first, input logic last);
        while (idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        data_byte       <= d;
        byte_index      <= idx;
        first_of_string <= first;
        last_of_string  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_step(d, idx, first, last);
    endtask

    // Hold the sender off until every outstanding hash has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_hashes.size() != 0);
    endtask

    // One-byte strings at the field extremes, with and without the first flag.
    task automatic test_one_byte_strings();
        feed_byte(8'h00, 8'h00, 1'b1, 1'b1);
        feed_byte(8'hFF, 8'hFF, 1'b1, 1'b1);
        feed_byte(8'hFF, 8'h00, 1'b1, 1'b1);
        // No first flag: state must already be fresh after the previous emission.
        feed_byte(8'h00, 8'hFF, 1'b0, 1'b1);
        feed_byte(8'h5A, 8'hA5, 1'b1, 1'b1);
    endtask

    // Multi-byte strings: normal flow, a string with no first flag, and a restart
    // in the middle of a string.
    task automatic test_multi_byte_strings();
        feed_byte(8'h41, 8'd3, 1'b1, 1'b0);
        feed_byte(8'hFF, 8'd2, 1'b0, 1'b0);
        feed_byte(8'h80, 8'd1, 1'b0, 1'b0);
        feed_byte(8'h7F, 8'd0, 1'b0, 1'b1);

        feed_byte(8'hFF, 8'd2, 1'b0, 1'b0);
        feed_byte(8'hFF, 8'd1, 1'b0, 1'b0);
        feed_byte(8'h00, 8'd0, 1'b0, 1'b1);

        feed_byte(8'h12, 8'd5, 1'b1, 1'b0);
        feed_byte(8'h34, 8'd4, 1'b0, 1'b0);
        feed_byte(8'hFF, 8'd3, 1'b1, 1'b0);
        feed_byte(8'hAA, 8'd2, 1'b0, 1'b0);
        feed_byte(8'h55, 8'd1, 1'b0, 1'b0);
        feed_byte(8'hC3, 8'd0, 1'b0, 1'b1);
    endtask

    // A string longer than the table so the offset wraps, fed after a full drain.
    task automatic test_long_string();
        int unsigned k;
        wait_for_drain();
        for (k = 130; k > 0; k--)
            feed_byte(8'($urandom), 8'(k - 1), k == 130, k == 1);
    endtask

    // Mostly well-formed strings with random content, plus noise bytes and
    // strings cut off before their last byte.
    task automatic test_random_strings();
        int unsigned sent;
        int unsigned len;
        int unsigned stop_at;
        int unsigned k;
        logic [7:0]  d;
        logic        top_first;
        sent = 0;
        while (sent < 360)
        begin
            // Run a stretch with no idling on either side.
            idle_on = !(sent >= 150 && sent < 230);
            if ($urandom_range(99) < 10)
            begin
                feed_byte(8'($urandom), 8'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
                top_first = ($urandom_range(99) < 85);
                // Drop the tail of about one string in ten.
                stop_at = ($urandom_range(9) == 0) ? $urandom_range(len, 1) : 0;
                for (k = len; k > stop_at; k--)
                begin
                    case ($urandom_range(7))
                        0:       d = 8'hFF;
                        1:       d = 8'h00;
                        default: d = 8'($urandom);
                    endcase
                    feed_byte(d, 8'(k - 1), top_first && k == len, k == 1);
                    sent++;
                end
            end
            if ($urandom_range(29) == 0)
                wait_for_drain();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        restart_hash();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_one_byte_strings();
        test_multi_byte_strings();
        test_long_string();
        test_random_strings();

        // Drop valid, drain outstanding hashes, then allow for a stray late output.
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (2 * HASH_LATENCY) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
